// File: rtl/cob_pkg.sv
// Shared types, constants and helpers for the cursor overlay blend unit.
// No dependencies; imported by cob_result_queue and cursor_overlay_blend_unit.
package cob_pkg;

  localparam int CURSOR_MAX_SIDE_DEF = 64;
  localparam int FRAME_MAX_SIDE_DEF  = 8192;

  localparam int IDX_W    = 12;
  localparam int COORD_W  = 13;
  localparam int OFFS_W   = 14;
  localparam int SIDE_W   = 7;
  localparam int PIX_W    = 32;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd4;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_BLEND = 1'b1;

  // result queue, power of two
  localparam int RES_QUEUE_DEPTH = 8;
  localparam int RQ_AW = $clog2(RES_QUEUE_DEPTH);

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             blended;
  } cob_result_t;

  // floor(x / 255), exact for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'd1 + 17'(x[15:8]);
    return t[15:8];
  endfunction

endpackage

// File: rtl/cob_result_queue.sv
// Result queue for the cursor overlay blend unit: holds finished items
// until the output side takes them. Depends on cob_pkg.
module cob_result_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cob_pkg::cob_result_t push_data,
  input  logic                pop,
  output logic                not_empty,
  output cob_pkg::cob_result_t head
);
  import cob_pkg::*;

  cob_result_t     entries_r [RES_QUEUE_DEPTH];
  logic [RQ_AW:0]  wr_ptr_r;
  logic [RQ_AW:0]  rd_ptr_r;

  assign not_empty = (wr_ptr_r != rd_ptr_r);
  assign head      = entries_r[rd_ptr_r[RQ_AW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop && not_empty) rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r[RQ_AW-1:0]] <= push_data;
  end

endmodule

// File: rtl/cursor_overlay_blend_unit.sv
// Cursor overlay blend unit: premultiplied-alpha cursor painted over frame pixels.
// A blend item passes the stage registers and the result queue before the output.
// Throughput: one item per cycle while in_ready is high; the cursor store is
// a single-port memory used by either a write or a read in one fixed stage.
// Up to 8 blend items may be in flight or queued, set by the result queue depth.
// Reset clears configuration, pipeline and queue; the cursor store is not cleared.
// Depends on cob_pkg and cob_result_queue.
module cursor_overlay_blend_unit #(
  parameter int CURSOR_MAX_SIDE = cob_pkg::CURSOR_MAX_SIDE_DEF,
  parameter int FRAME_MAX_SIDE  = cob_pkg::FRAME_MAX_SIDE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cob_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cob_pkg::OFFS_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic [cob_pkg::IDX_W-1:0]     in_cursor_index,
  input  logic [cob_pkg::PIX_W-1:0]     in_cursor_word,
  input  logic [cob_pkg::COORD_W-1:0]   in_column,
  input  logic [cob_pkg::COORD_W-1:0]   in_row,
  input  logic [cob_pkg::PIX_W-1:0]     in_frame_pixel,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cob_pkg::PIX_W-1:0]     out_pixel,
  output logic                          out_blended
);
  import cob_pkg::*;

  localparam int STORE_DEPTH = CURSOR_MAX_SIDE * CURSOR_MAX_SIDE;
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W = $clog2(RES_QUEUE_DEPTH + 1);

  // remainder of v by the store depth, restoring steps k_hi down to k_lo
  function automatic logic [IDX_W-1:0] idx_reduce(input logic [IDX_W-1:0] v_in,
                                                  input int k_hi, input int k_lo);
    logic [IDX_W-1:0] v;
    longint           sub;
    v = v_in;
    for (int k = IDX_W - 1; k >= 0; k--) begin
      sub = longint'(STORE_DEPTH) << k;
      if (k <= k_hi && k >= k_lo && sub < (longint'(1) << IDX_W) && longint'(v) >= sub)
        v = v - IDX_W'(sub);
    end
    return v;
  endfunction

  // configuration
  logic                     cfg_enable_r;
  logic signed [OFFS_W-1:0] cfg_left_r;
  logic signed [OFFS_W-1:0] cfg_top_r;
  logic [SIDE_W-1:0]        cfg_width_r;
  logic [SIDE_W-1:0]        cfg_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_enable_r <= 1'b0;
      cfg_left_r   <= '0;
      cfg_top_r    <= '0;
      cfg_width_r  <= '0;
      cfg_height_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE: cfg_enable_r <= cfg_wdata[0];
        CFG_LEFT:   cfg_left_r   <= cfg_wdata;
        CFG_TOP:    cfg_top_r    <= cfg_wdata;
        CFG_WIDTH:  cfg_width_r  <= cfg_wdata[SIDE_W-1:0];
        CFG_HEIGHT: cfg_height_r <= cfg_wdata[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SIDE_W-1:0] w_sat;
  logic [SIDE_W-1:0] h_sat;
  assign w_sat = (int'(cfg_width_r) > CURSOR_MAX_SIDE) ? SIDE_W'(CURSOR_MAX_SIDE) : cfg_width_r;
  assign h_sat = (int'(cfg_height_r) > CURSOR_MAX_SIDE) ? SIDE_W'(CURSOR_MAX_SIDE) : cfg_height_r;

  // credit for blend items in flight or queued
  logic [CNT_W-1:0] cnt_r;
  logic             in_acc;
  logic             out_acc;
  logic             blend_acc;

  assign in_ready  = (int'(cnt_r) < RES_QUEUE_DEPTH);
  assign in_acc    = in_valid && in_ready;
  assign blend_acc = in_acc && (in_mode == MODE_BLEND);
  assign out_acc   = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      unique case ({blend_acc, out_acc})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // stage valids
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;

  // stage 1: registered input item
  logic               s1_mode_r;
  logic [IDX_W-1:0]   s1_index_r;
  logic [PIX_W-1:0]   s1_word_r;
  logic [COORD_W-1:0] s1_col_r;
  logic [COORD_W-1:0] s1_row_r;
  logic [PIX_W-1:0]   s1_pix_r;

  logic signed [OFFS_W:0] s1_i;
  logic signed [OFFS_W:0] s1_j;
  logic                   s1_hit;
  logic [2*SIDE_W-1:0]    s1_prod;

  assign s1_i = $signed({2'b00, s1_col_r}) - $signed({cfg_left_r[OFFS_W-1], cfg_left_r});
  assign s1_j = $signed({2'b00, s1_row_r}) - $signed({cfg_top_r[OFFS_W-1], cfg_top_r});
  assign s1_hit = cfg_enable_r
                  && (int'(s1_col_r) < FRAME_MAX_SIDE) && (int'(s1_row_r) < FRAME_MAX_SIDE)
                  && !s1_i[OFFS_W] && (s1_i[OFFS_W-1:0] < OFFS_W'(w_sat))
                  && !s1_j[OFFS_W] && (s1_j[OFFS_W-1:0] < OFFS_W'(h_sat));
  assign s1_prod = s1_j[SIDE_W-1:0] * w_sat;

  // stage 2
  logic               s2_mode_r;
  logic               s2_hit_r;
  logic [AW-1:0]      s2_prod_r;
  logic [SIDE_W-1:0]  s2_i_r;
  logic [IDX_W-1:0]   s2_idx_r;
  logic [PIX_W-1:0]   s2_word_r;
  logic [PIX_W-1:0]   s2_pix_r;
  logic [AW-1:0]      s2_addr;

  assign s2_addr = (s2_mode_r == MODE_BLEND) ? (s2_prod_r + AW'(s2_i_r))
                                             : AW'(idx_reduce(s2_idx_r, IDX_W / 2 - 1, 0));

  // cursor store, one access a cycle
  logic [PIX_W-1:0] store_mem [STORE_DEPTH];
  logic [PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      if (s2_mode_r == MODE_WRITE) store_mem[s2_addr] <= s2_word_r;
      else rdata_r <= store_mem[s2_addr];
    end
  end

  // stage 3: store data back, weight frame channels by 255 - alpha
  logic             s3_hit_r;
  logic [PIX_W-1:0] s3_pix_r;
  logic [7:0]       s3_alpha;
  logic [7:0]       s3_inv;

  assign s3_alpha = rdata_r[31:24];
  assign s3_inv   = 8'd255 - s3_alpha;

  // stage 4
  logic             s4_blend_r;
  logic [PIX_W-1:0] s4_pix_r;
  logic [23:0]      s4_curs_r;
  logic [15:0]      s4_prod_r [3];
  logic [7:0]       s4_ch [3];
  cob_result_t      s4_res;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s4_ch[c] = s4_curs_r[8*c +: 8] + div255(s4_prod_r[c]);
    end
    s4_res.blended = s4_blend_r;
    s4_res.pixel   = s4_blend_r ? {8'h00, s4_ch[2], s4_ch[1], s4_ch[0]} : s4_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
      s2_v_r <= s1_v_r;
      // write items end at the store
      s3_v_r <= s2_v_r && (s2_mode_r == MODE_BLEND);
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r  <= in_mode;
      s1_index_r <= in_cursor_index;
      s1_word_r  <= in_cursor_word;
      s1_col_r   <= in_column;
      s1_row_r   <= in_row;
      s1_pix_r   <= in_frame_pixel;
    end
    s2_mode_r <= s1_mode_r;
    s2_hit_r  <= s1_hit;
    s2_prod_r <= AW'(s1_prod);
    s2_i_r    <= s1_i[SIDE_W-1:0];
    s2_idx_r  <= idx_reduce(s1_index_r, IDX_W - 1, IDX_W / 2);
    s2_word_r <= s1_word_r;
    s2_pix_r  <= s1_pix_r;

    s3_hit_r <= s2_hit_r;
    s3_pix_r <= s2_pix_r;

    s4_blend_r <= s3_hit_r && (s3_alpha != 8'd0);
    s4_pix_r   <= s3_pix_r;
    s4_curs_r  <= rdata_r[23:0];
    for (int c = 0; c < 3; c++) begin
      s4_prod_r[c] <= s3_pix_r[8*c +: 8] * s3_inv;
    end
  end

  cob_result_t q_head;

  cob_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s4_v_r),
    .push_data (s4_res),
    .pop       (out_ready),
    .not_empty (out_valid),
    .head      (q_head)
  );

  assign out_pixel   = q_head.pixel;
  assign out_blended = q_head.blended;

endmodule

// File: bench/tb_cursor_overlay_blend_unit.sv
// Self-checking bench for cursor_overlay_blend_unit: cursor store loads, pixel blends, clipping.
// Holds its own overlay predictor and random valid/ready traffic on both channels.
// Depends on cob_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module tb_cursor_overlay_blend_unit;
  import cob_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic               mode;
    logic [IDX_W-1:0]   idx;
    logic [PIX_W-1:0]   word;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   fpix;
  } overlay_item_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [OFFS_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_mode = MODE_WRITE;
  logic [IDX_W-1:0]     in_cursor_index = '0;
  logic [PIX_W-1:0]     in_cursor_word = '0;
  logic [COORD_W-1:0]   in_column = '0;
  logic [COORD_W-1:0]   in_row = '0;
  logic [PIX_W-1:0]     in_frame_pixel = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIX_W-1:0]     out_pixel;
  logic                 out_blended;

  // predictor copy of the registers and the cursor store
  logic               ov_enable = 1'b0;
  int                 ov_left = 0;
  int                 ov_top = 0;
  int                 ov_width = 0;
  int                 ov_height = 0;
  logic [PIX_W-1:0]   cursor_words [0:4095];
  // which store entries the generator has already loaded
  bit                 word_loaded [0:4095];

  overlay_item_t      pending_items [$];
  cob_result_t        expected_pixels [$];
  overlay_item_t      next_item;
  int                 items_queued = 0;
  int                 items_accepted = 0;
  int                 mismatch_count = 0;
  int                 cycle_count = 0;
  int                 in_idle_pct = 0;
  int                 out_stall_pct = 0;
  int                 in_gap = 0;
  int                 out_gap = 0;
  logic               in_taken = 1'b0;

  cursor_overlay_blend_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_cursor_index (in_cursor_index),
    .in_cursor_word  (in_cursor_word),
    .in_column       (in_column),
    .in_row          (in_row),
    .in_frame_pixel  (in_frame_pixel),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel       (out_pixel),
    .out_blended     (out_blended)
  );

  always #10 clk = ~clk;

  function automatic int eff_side(input int s);
    return (s > CURSOR_MAX_SIDE_DEF) ? CURSOR_MAX_SIDE_DEF : s;
  endfunction

  // true when the pixel falls inside the enabled cursor rectangle; addr is the store entry
  function automatic bit cursor_covers(input logic [COORD_W-1:0] col,
                                       input logic [COORD_W-1:0] row,
                                       output logic [IDX_W-1:0] addr);
    int i, j, w, h;
    w = eff_side(ov_width);
    h = eff_side(ov_height);
    i = int'(col) - ov_left;
    j = int'(row) - ov_top;
    addr = '0;
    if (!ov_enable || i < 0 || j < 0 || i >= w || j >= h) return 1'b0;
    addr = IDX_W'(j * w + i);
    return 1'b1;
  endfunction

  function automatic logic [7:0] over_channel(input logic [7:0] c, input logic [7:0] d,
                                              input logic [7:0] a);
    return 8'((int'(c) + int'(d) * (255 - int'(a)) / 255) & 255);
  endfunction

  function automatic cob_result_t overlay_result(input logic [COORD_W-1:0] col,
                                                 input logic [COORD_W-1:0] row,
                                                 input logic [PIX_W-1:0] fpix);
    cob_result_t r;
    logic [IDX_W-1:0] addr;
    logic [PIX_W-1:0] cw;
    r.pixel = fpix;
    r.blended = 1'b0;
    if (cursor_covers(col, row, addr)) begin
      cw = cursor_words[addr];
      if (cw[31:24] != 8'h00) begin
        r.pixel = {8'h00, over_channel(cw[23:16], fpix[23:16], cw[31:24]),
                   over_channel(cw[15:8], fpix[15:8], cw[31:24]),
                   over_channel(cw[7:0], fpix[7:0], cw[31:24])};
        r.blended = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] rand_cursor_word();
    logic [PIX_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0: v[31:24] = 8'h00;
      1: v[31:24] = 8'hff;
      2: v[31:24] = 8'h01;
      3: v[23:0] = 24'hffffff;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] rand_frame_pixel();
    case ($urandom_range(0, 15))
      0: return 32'hffff_ffff;
      1: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_offset();
    case ($urandom_range(0, 9))
      0: return -64;
      1: return 8191;
      2: return -8192;
      3: return int'($signed(OFFS_W'($urandom)));
      default: return int'($urandom_range(0, 300)) - 64;
    endcase
  endfunction

  function automatic int pick_side();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 64;
      2: return int'($urandom_range(65, 127));
      3: return 1;
      default: return int'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic void queue_write(input logic [IDX_W-1:0] idx, input logic [PIX_W-1:0] word);
    overlay_item_t it;
    it.mode = MODE_WRITE;
    it.idx = idx;
    it.word = word;
    it.col = COORD_W'($urandom);
    it.row = COORD_W'($urandom);
    it.fpix = $urandom;
    pending_items.push_back(it);
    word_loaded[idx] = 1'b1;
    items_queued++;
  endfunction

  // never let a blend read a store entry that has not been loaded
  function automatic void queue_blend(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                                      input logic [PIX_W-1:0] fpix);
    overlay_item_t it;
    logic [IDX_W-1:0] addr;
    if (cursor_covers(col, row, addr) && !word_loaded[addr])
      queue_write(addr, rand_cursor_word());
    it.mode = MODE_BLEND;
    it.idx = IDX_W'($urandom);
    it.word = $urandom;
    it.col = col;
    it.row = row;
    it.fpix = fpix;
    pending_items.push_back(it);
    items_queued++;
  endfunction

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [OFFS_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ENABLE: ov_enable = value[0];
      CFG_LEFT:   ov_left = int'($signed(value));
      CFG_TOP:    ov_top = int'($signed(value));
      CFG_WIDTH:  ov_width = int'(value[SIDE_W-1:0]);
      CFG_HEIGHT: ov_height = int'(value[SIDE_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic apply_config(input bit en, input int left, input int top, input int w,
                              input int h);
    set_reg(CFG_ENABLE, OFFS_W'(en));
    set_reg(CFG_LEFT, OFFS_W'(left));
    set_reg(CFG_TOP, OFFS_W'(top));
    set_reg(CFG_WIDTH, OFFS_W'(w));
    set_reg(CFG_HEIGHT, OFFS_W'(h));
  endtask

  // store writes give no result, so let the pipeline empty after the last pixel
  task automatic wait_idle();
    while (items_accepted != items_queued || expected_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_random_phase(input bit no_idle);
    int w, h, c, r, n0;
    if (no_idle) begin
      in_idle_pct = 0;
      out_stall_pct = 0;
      apply_config(1'b1, int'($urandom_range(0, 40)), int'($urandom_range(0, 40)),
                   int'($urandom_range(1, 64)), int'($urandom_range(1, 64)));
    end else begin
      in_idle_pct = 8 * int'($urandom_range(0, 3));
      out_stall_pct = 8 * int'($urandom_range(0, 3));
      apply_config($urandom_range(0, 6) != 0, pick_offset(), pick_offset(), pick_side(),
                   pick_side());
    end
    w = eff_side(ov_width);
    h = eff_side(ov_height);
    // small cursor: load the whole image first, as a driver would
    if (ov_enable && w * h <= 48)
      for (int k = 0; k < w * h; k++) queue_write(IDX_W'(k), rand_cursor_word());
    n0 = items_queued;
    while (items_queued - n0 < 140) begin
      case ($urandom_range(0, 19))
        0, 1, 2: queue_write(IDX_W'($urandom), rand_cursor_word());
        3, 4, 5, 6: queue_blend(COORD_W'($urandom), COORD_W'($urandom), rand_frame_pixel());
        default: begin
          c = ov_left + int'($urandom_range(0, w + 3)) - 2;
          r = ov_top + int'($urandom_range(0, h + 3)) - 2;
          if (c < 0 || c > 8191) c = int'($urandom_range(0, 8191));
          if (r < 0 || r > 8191) r = int'($urandom_range(0, 8191));
          queue_blend(COORD_W'(c), COORD_W'(r), rand_frame_pixel());
        end
      endcase
    end
    wait_idle();
  endtask

  task automatic log_mismatch(input string what);
    $display("mismatch @%0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // item driver
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
        in_gap <= $urandom_range(0, 6);
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        next_item = pending_items.pop_front();
        in_valid <= 1'b1;
        in_mode <= next_item.mode;
        in_cursor_index <= next_item.idx;
        in_cursor_word <= next_item.word;
        in_column <= next_item.col;
        in_row <= next_item.row;
        in_frame_pixel <= next_item.fpix;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result sink back-pressure
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
      out_gap <= $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: check results first, then predict from the accepted item
  always @(posedge clk) begin
    cob_result_t want;
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb_cursor_overlay_blend_unit: done, errors");
      $finish;
    end else begin
      in_taken <= rst_n && in_valid && in_ready;
      if (rst_n) begin
        if (out_valid && out_ready) begin
          if (expected_pixels.size() == 0) begin
            log_mismatch($sformatf("result %h/%b with no pixel outstanding",
                                   out_pixel, out_blended));
          end else begin
            want = expected_pixels.pop_front();
            if (out_pixel !== want.pixel)
              log_mismatch($sformatf("pixel %h, want %h", out_pixel, want.pixel));
            if (out_blended !== want.blended)
              log_mismatch($sformatf("blended %b, want %b", out_blended, want.blended));
          end
        end
        if (in_valid && in_ready) begin
          items_accepted++;
          if (in_mode == MODE_WRITE) cursor_words[in_cursor_index] = in_cursor_word;
          else expected_pixels.push_back(overlay_result(in_column, in_row, in_frame_pixel));
        end
      end
    end
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    in_idle_pct = 10;
    out_stall_pct = 10;

    // registers at reset: painting off, pixels pass whole
    queue_write(12'd4095, 32'hff80_ff01);
    queue_write(12'd0, 32'h80ff_ffff);
    queue_blend(13'd0, 13'd0, 32'hffff_ffff);
    queue_blend(13'h1fff, 13'h1fff, 32'h0000_0000);
    wait_idle();

    // 3x2 cursor at (5,3): zero alpha, full alpha, channel wrap, edges
    apply_config(1'b1, 5, 3, 3, 2);
    queue_write(12'd0, 32'h0012_3456);
    queue_write(12'd1, 32'hff00_0000);
    queue_write(12'd2, 32'h01ff_ffff);
    queue_write(12'd3, 32'h8040_2010);
    queue_write(12'd4, 32'hffff_ffff);
    queue_write(12'd5, 32'h7f00_ff80);
    queue_blend(13'd5, 13'd3, 32'haabb_ccdd);
    queue_blend(13'd6, 13'd3, 32'h1234_5678);
    queue_blend(13'd7, 13'd3, 32'hffff_ffff);
    queue_blend(13'd5, 13'd4, 32'hff80_40c0);
    queue_blend(13'd6, 13'd4, 32'h00ff_ffff);
    queue_blend(13'd7, 13'd4, 32'h0000_0000);
    queue_blend(13'd4, 13'd3, 32'h1111_1111);
    queue_blend(13'd8, 13'd3, 32'h2222_2222);
    queue_blend(13'd5, 13'd2, 32'h3333_3333);
    queue_blend(13'd5, 13'd5, 32'h4444_4444);
    wait_idle();

    // oversized cursor saturates to 64x64, negative offsets
    apply_config(1'b1, -63, -63, 127, 100);
    queue_blend(13'd0, 13'd0, 32'h5566_7788);
    queue_blend(13'd1, 13'd0, 32'h99aa_bbcc);
    queue_blend(13'd0, 13'd1, 32'hddee_ff00);
    wait_idle();

    // far corner: zero width first, then one column
    apply_config(1'b1, 8191, 8191, 0, 64);
    queue_blend(13'h1fff, 13'h1fff, 32'hffff_ffff);
    wait_idle();
    set_reg(CFG_WIDTH, OFFS_W'(1));
    queue_blend(13'h1fff, 13'h1fff, 32'hffff_ffff);
    wait_idle();

    for (int p = 0; p < 12; p++) run_random_phase(p == 11);

    if (mismatch_count == 0) $display("tb_cursor_overlay_blend_unit: done, clean");
    else $display("tb_cursor_overlay_blend_unit: done, errors");
    $finish;
  end

endmodule
